>>> rtl/core/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared sizes, types and helpers of the threshold component counter.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int unsigned MAX_ROWS   = 256;
	localparam int unsigned MAX_COLS   = 256;
	localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
	localparam int unsigned COL_W      = $clog2(MAX_COLS);
	// map address is {row, col}; column count is a power of two
	localparam int unsigned ADDR_W     = ROW_W + COL_W;
	localparam int unsigned PTR_W      = ADDR_W + 1;
	localparam int unsigned DIM_W      = 9;
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned SUM_W      = PIX_W + 2;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned THR_SCALE  = 3;

	// configuration register indexes; the last one is unused
	typedef enum logic [1:0] {
		CFG_ROWS      = 2'd0,
		CFG_COLS      = 2'd1,
		CFG_THRESHOLD = 2'd2,
		CFG_SPARE     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic              fg;
	} fg_wr_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] count;
	} lab_stat_t;

	// zero acts as one, anything above the limit acts as the limit
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > lim) begin
			r = lim;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tcc_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_loader
// Raster write position and foreground threshold for incoming pixels.
// ----------------------------------------------------------------------------
module tcc_loader (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [tcc_pkg::PIX_W-1:0]       red,
	input  logic [tcc_pkg::PIX_W-1:0]       green,
	input  logic [tcc_pkg::PIX_W-1:0]       blue,
	input  logic                            last_pixel,
	input  logic [tcc_pkg::DIM_W-1:0]       rows,
	input  logic [tcc_pkg::DIM_W-1:0]       cols,
	input  logic [tcc_pkg::PIX_W-1:0]       threshold,
	output tcc_pkg::fg_wr_t                 fg_wr
);

	logic [tcc_pkg::ROW_W-1:0] row_q;
	logic [tcc_pkg::COL_W-1:0] col_q;
	logic [tcc_pkg::DIM_W-1:0] row_a, col_a, row_n, col_n;
	logic [tcc_pkg::SUM_W-1:0] sum, limit;

	always_comb begin
		sum   = tcc_pkg::SUM_W'(red) + tcc_pkg::SUM_W'(green) + tcc_pkg::SUM_W'(blue);
		limit = tcc_pkg::SUM_W'(threshold) * tcc_pkg::SUM_W'(tcc_pkg::THR_SCALE);

		// move into the current size first if it shrank while loading
		col_a = tcc_pkg::DIM_W'(col_q);
		row_a = tcc_pkg::DIM_W'(row_q);
		if (col_a >= cols) begin
			col_a = '0;
			row_a = row_a + tcc_pkg::DIM_W'(1);
		end
		if (row_a >= rows) begin
			row_a = '0;
		end

		col_n = col_a + tcc_pkg::DIM_W'(1);
		row_n = row_a;
		if (col_n >= cols) begin
			col_n = '0;
			row_n = row_a + tcc_pkg::DIM_W'(1);
			if (row_n >= rows) begin
				row_n = '0;
			end
		end
		if (last_pixel) begin
			row_n = '0;
			col_n = '0;
		end

		fg_wr.en   = take;
		fg_wr.addr = {row_a[tcc_pkg::ROW_W-1:0], col_a[tcc_pkg::COL_W-1:0]};
		fg_wr.fg   = (sum >= limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			row_q <= row_n[tcc_pkg::ROW_W-1:0];
			col_q <= col_n[tcc_pkg::COL_W-1:0];
		end
	end

endmodule

>>> rtl/core/tcc_labeler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_labeler
// Foreground, visited and coordinate memories with the clear, scan and
// breadth-first flood sequencer that counts 4-connected components.
// ----------------------------------------------------------------------------
module tcc_labeler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tcc_pkg::fg_wr_t           fg_wr,
	input  logic                      start,
	input  logic                      result_taken,
	input  logic [tcc_pkg::DIM_W-1:0] rows,
	input  logic [tcc_pkg::DIM_W-1:0] cols,
	output tcc_pkg::lab_stat_t        stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_FL_POP,
		S_FL_CUR,
		S_FL_NRD,
		S_FL_NCHK,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIR_E,
		DIR_S,
		DIR_W,
		DIR_N
	} dir_t;

	localparam int unsigned DEPTH = tcc_pkg::MAX_ROWS * tcc_pkg::MAX_COLS;

	logic fg_mem  [DEPTH];
	logic vis_mem [DEPTH];
	logic [tcc_pkg::ADDR_W-1:0] fifo_mem [DEPTH];

	state_t state_q;
	dir_t   dir_q;

	logic [tcc_pkg::ROW_W-1:0]  scan_row_q, cur_row_q;
	logic [tcc_pkg::COL_W-1:0]  scan_col_q, cur_col_q;
	logic [tcc_pkg::ADDR_W-1:0] nb_addr_q;
	logic [tcc_pkg::PTR_W-1:0]  head_q, tail_q;
	logic [tcc_pkg::CNT_W-1:0]  cnt_q;

	logic                       fg_rd_q, vis_rd_q;
	logic [tcc_pkg::ADDR_W-1:0] fifo_rd_q;

	logic [tcc_pkg::ADDR_W-1:0] scan_addr, rd_addr, nb_addr;
	logic                       nb_ok, hit, col_wrap, scan_last;
	logic [tcc_pkg::DIM_W-1:0]  col_inc, row_inc, cur_c9, cur_r9;

	logic                       vis_we, vis_wd;
	logic [tcc_pkg::ADDR_W-1:0] vis_wa;
	logic                       fifo_we;
	logic [tcc_pkg::ADDR_W-1:0] fifo_wa, fifo_wd;

	always_comb begin
		scan_addr = {scan_row_q, scan_col_q};
		col_inc   = tcc_pkg::DIM_W'(scan_col_q) + tcc_pkg::DIM_W'(1);
		row_inc   = tcc_pkg::DIM_W'(scan_row_q) + tcc_pkg::DIM_W'(1);
		col_wrap  = (col_inc >= cols);
		scan_last = col_wrap && (row_inc >= rows);
		hit       = fg_rd_q && !vis_rd_q;

		cur_c9 = tcc_pkg::DIM_W'(cur_col_q);
		cur_r9 = tcc_pkg::DIM_W'(cur_row_q);
		case (dir_q)
			DIR_E: begin
				nb_ok   = (cur_c9 + tcc_pkg::DIM_W'(1)) < cols;
				nb_addr = {cur_row_q, cur_col_q + tcc_pkg::COL_W'(1)};
			end
			DIR_S: begin
				nb_ok   = (cur_r9 + tcc_pkg::DIM_W'(1)) < rows;
				nb_addr = {cur_row_q + tcc_pkg::ROW_W'(1), cur_col_q};
			end
			DIR_W: begin
				nb_ok   = (cur_col_q != '0);
				nb_addr = {cur_row_q, cur_col_q - tcc_pkg::COL_W'(1)};
			end
			DIR_N: begin
				nb_ok   = (cur_row_q != '0);
				nb_addr = {cur_row_q - tcc_pkg::ROW_W'(1), cur_col_q};
			end
			default: begin
				nb_ok   = 1'b0;
				nb_addr = {cur_row_q, cur_col_q};
			end
		endcase

		rd_addr = (state_q == S_FL_NRD) ? nb_addr : scan_addr;

		vis_we  = 1'b0;
		vis_wd  = 1'b1;
		vis_wa  = scan_addr;
		fifo_we = 1'b0;
		fifo_wa = tail_q[tcc_pkg::ADDR_W-1:0];
		fifo_wd = scan_addr;
		case (state_q)
			S_CLEAR: begin
				vis_we = 1'b1;
				vis_wd = 1'b0;
			end
			S_SCAN_CHK: begin
				// seed a new flood at queue slot zero
				vis_we  = hit;
				fifo_we = hit;
				fifo_wa = '0;
			end
			S_FL_NCHK: begin
				vis_we  = hit;
				vis_wa  = nb_addr_q;
				fifo_we = hit;
				fifo_wd = nb_addr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fg_wr.en) begin
			fg_mem[fg_wr.addr] <= fg_wr.fg;
		end
		fg_rd_q <= fg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		vis_rd_q <= vis_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[fifo_wa] <= fifo_wd;
		end
		fifo_rd_q <= fifo_mem[head_q[tcc_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dir_q      <= DIR_E;
			scan_row_q <= '0;
			scan_col_q <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			nb_addr_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_row_q <= '0;
						scan_col_q <= '0;
						cnt_q      <= '0;
						state_q    <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					if (scan_last) begin
						scan_row_q <= '0;
						scan_col_q <= '0;
						state_q    <= S_SCAN_RD;
					end else if (col_wrap) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + tcc_pkg::ROW_W'(1);
					end else begin
						scan_col_q <= scan_col_q + tcc_pkg::COL_W'(1);
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK, S_FL_POP: begin
					if (state_q == S_SCAN_CHK && hit) begin
						head_q <= '0;
						tail_q <= tcc_pkg::PTR_W'(1);
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + tcc_pkg::CNT_W'(1);
						end
						state_q <= S_FL_POP;
					end else if (state_q == S_FL_POP && head_q != tail_q) begin
						head_q  <= head_q + tcc_pkg::PTR_W'(1);
						state_q <= S_FL_CUR;
					end else if (scan_last) begin
						state_q <= S_DONE;
					end else begin
						// advance the raster scan
						if (col_wrap) begin
							scan_col_q <= '0;
							scan_row_q <= scan_row_q + tcc_pkg::ROW_W'(1);
						end else begin
							scan_col_q <= scan_col_q + tcc_pkg::COL_W'(1);
						end
						state_q <= S_SCAN_RD;
					end
				end
				S_FL_CUR: begin
					cur_row_q <= fifo_rd_q[tcc_pkg::ADDR_W-1:tcc_pkg::COL_W];
					cur_col_q <= fifo_rd_q[tcc_pkg::COL_W-1:0];
					dir_q     <= DIR_E;
					state_q   <= S_FL_NRD;
				end
				S_FL_NRD: begin
					if (nb_ok) begin
						nb_addr_q <= nb_addr;
						state_q   <= S_FL_NCHK;
					end else if (dir_q == DIR_N) begin
						state_q <= S_FL_POP;
					end else begin
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				S_FL_NCHK: begin
					if (hit) begin
						tail_q <= tail_q + tcc_pkg::PTR_W'(1);
					end
					if (dir_q == DIR_N) begin
						state_q <= S_FL_POP;
					end else begin
						dir_q   <= dir_t'(dir_q + 2'd1);
						state_q <= S_FL_NRD;
					end
				end
				S_DONE: begin
					if (result_taken) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.busy  = (state_q != S_IDLE);
	assign stat.done  = (state_q == S_DONE);
	assign stat.count = cnt_q;

endmodule

>>> rtl/core/threshold_component_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_component_counter
// Counts 4-connected foreground components of a thresholded RGB image.
//
// Pixels arrive in raster order, one per cycle while the block is idle; each
// is reduced to a foreground bit (red+green+blue at least three times the
// threshold) and written to an on-chip map of up to 256 x 256 entries. The
// pixel flagged last_pixel starts labeling, during which input is stalled.
// Labeling first clears the visited map over the configured area, then scans
// it pixel by pixel, reading and checking each; an unvisited foreground pixel
// seeds a breadth-first flood that pops each queued pixel and reads and checks
// its in-image neighbors east, south, west and north in turn, queuing those
// that are unvisited foreground, until the queue is empty. The pace comes from
// the read-check-write loop on the visited memory and its registered read. The
// single result, the component count saturating at 65535, waits in an output
// register, and further pixels of the next image are accepted meanwhile.
// ----------------------------------------------------------------------------
module threshold_component_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tcc_pkg::PIX_W-1:0]   red,
	input  logic [tcc_pkg::PIX_W-1:0]   green,
	input  logic [tcc_pkg::PIX_W-1:0]   blue,
	input  logic                        last_pixel,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcc_pkg::CNT_W-1:0]   component_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [tcc_pkg::DIM_W-1:0]   cfg_data
);

	logic [tcc_pkg::DIM_W-1:0] rows_q, cols_q, rows_used, cols_used;
	logic [tcc_pkg::PIX_W-1:0] thr_q;
	logic                      take, result_taken, out_valid_q;
	logic [tcc_pkg::CNT_W-1:0] count_q;
	tcc_pkg::fg_wr_t           fg_wr;
	tcc_pkg::lab_stat_t        stat;

	assign cfg_ready = 1'b1;
	assign rows_used = tcc_pkg::clamp_dim(rows_q, tcc_pkg::DIM_W'(tcc_pkg::MAX_ROWS));
	assign cols_used = tcc_pkg::clamp_dim(cols_q, tcc_pkg::DIM_W'(tcc_pkg::MAX_COLS));

	assign in_stall     = stat.busy;
	assign take         = in_valid && !in_stall;
	assign result_taken = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= tcc_pkg::DIM_W'(tcc_pkg::MAX_ROWS);
			cols_q <= tcc_pkg::DIM_W'(tcc_pkg::MAX_COLS);
			thr_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (tcc_pkg::cfg_idx_t'(cfg_index))
				tcc_pkg::CFG_ROWS:      rows_q <= cfg_data;
				tcc_pkg::CFG_COLS:      cols_q <= cfg_data;
				tcc_pkg::CFG_THRESHOLD: thr_q  <= cfg_data[tcc_pkg::PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcc_loader u_loader (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel),
		.rows       (rows_used),
		.cols       (cols_used),
		.threshold  (thr_q),
		.fg_wr      (fg_wr)
	);

	tcc_labeler u_labeler (
		.clk          (clk),
		.arst_n       (arst_n),
		.fg_wr        (fg_wr),
		.start        (take && last_pixel),
		.result_taken (result_taken),
		.rows         (rows_used),
		.cols         (cols_used),
		.stat         (stat)
	);

	// hold the count until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && result_taken) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && result_taken) begin
			count_q <= stat.count;
		end
	end

	assign out_valid       = out_valid_q;
	assign component_count = count_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the threshold component counter. Loads RGB images
// of many sizes and thresholds, predicts each component count with its own
// flood-fill model and compares every count the block returns, under random
// stalls and gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import tcc_pkg::*;

	localparam int unsigned MAP_DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int unsigned COUNT_SAT     = (1 << CNT_W) - 1;
	localparam int unsigned QUIET_CYCLES  = 32;
	localparam int unsigned HOLD_CYCLES   = 3000;
	localparam int unsigned RANDOM_PIXELS = 1800;
	localparam int unsigned CALM_AFTER    = 1500;
	localparam longint unsigned LIMIT_NS  = 64'd50_000_000;

	class component_scoreboard;
		bit fg_map [MAP_DEPTH];
		bit written [MAP_DEPTH];
		bit visited [MAP_DEPTH];
		int unsigned flood_queue [$];
		int unsigned expected_counts [$];
		logic [DIM_W-1:0] rows_reg = DIM_W'(MAX_ROWS);
		logic [DIM_W-1:0] cols_reg = DIM_W'(MAX_COLS);
		logic [PIX_W-1:0] thr_reg = '0;
		int unsigned load_row = 0;
		int unsigned load_col = 0;
		int errors = 0;
		int checked = 0;

		function int unsigned rows_used();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAX_ROWS) return MAX_ROWS;
			return 32'(rows_reg);
		endfunction

		function int unsigned cols_used();
			if (cols_reg == 0) return 1;
			if (cols_reg > MAX_COLS) return MAX_COLS;
			return 32'(cols_reg);
		endfunction

		function void apply_reg(cfg_idx_t idx, logic [DIM_W-1:0] data);
			case (idx)
				CFG_ROWS: rows_reg = data;
				CFG_COLS: cols_reg = data;
				CFG_THRESHOLD: thr_reg = data[PIX_W-1:0];
				default: ;
			endcase
		endfunction

		// where the next pixel lands, after pulling the position back into the image
		function int unsigned next_write_index();
			int unsigned row, col;
			row = load_row;
			col = load_col;
			if (col >= cols_used()) begin
				col = 0;
				row++;
			end
			if (row >= rows_used()) row = 0;
			return row * MAX_COLS + col;
		endfunction

		// true when a last pixel sent now would leave no unwritten entry in the image
		function bit region_ready();
			int unsigned nxt, r, c, idx;
			nxt = next_write_index();
			for (r = 0; r < rows_used(); r++) begin
				for (c = 0; c < cols_used(); c++) begin
					idx = r * MAX_COLS + c;
					if (!written[idx] && idx != nxt) return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void enqueue_cell(int unsigned idx);
			if (fg_map[idx] && !visited[idx]) begin
				visited[idx] = 1'b1;
				flood_queue.push_back(idx);
			end
		endfunction

		function int unsigned count_components();
			int unsigned rows, cols, r, c, idx, cur, cr, cc, total;
			rows = rows_used();
			cols = cols_used();
			total = 0;
			for (r = 0; r < rows; r++)
				for (c = 0; c < cols; c++)
					visited[r * MAX_COLS + c] = 1'b0;
			for (r = 0; r < rows; r++) begin
				for (c = 0; c < cols; c++) begin
					idx = r * MAX_COLS + c;
					if (fg_map[idx] && !visited[idx]) begin
						enqueue_cell(idx);
						while (flood_queue.size() != 0) begin
							cur = flood_queue.pop_front();
							cr = cur / MAX_COLS;
							cc = cur % MAX_COLS;
							if (cc + 1 < cols) enqueue_cell(cur + 1);
							if (cr + 1 < rows) enqueue_cell(cur + MAX_COLS);
							if (cc > 0) enqueue_cell(cur - 1);
							if (cr > 0) enqueue_cell(cur - MAX_COLS);
						end
						if (total < COUNT_SAT) total++;
					end
				end
			end
			return total;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b, logic last);
			int unsigned idx, row, col, total_sum;
			idx = next_write_index();
			row = idx / MAX_COLS;
			col = idx % MAX_COLS;
			total_sum = int'(r) + int'(g) + int'(b);
			fg_map[idx] = (total_sum >= THR_SCALE * int'(thr_reg));
			written[idx] = 1'b1;
			col++;
			if (col >= cols_used()) begin
				col = 0;
				row++;
				if (row >= rows_used()) row = 0;
			end
			load_row = row;
			load_col = col;
			if (last) begin
				expected_counts.push_back(count_components());
				load_row = 0;
				load_col = 0;
			end
		endfunction

		function void check_count(logic [CNT_W-1:0] actual);
			logic [CNT_W-1:0] want;
			checked++;
			if (expected_counts.size() == 0) begin
				errors++;
				$display("%0t: component_count expected none, actual %0d",
					$time, actual);
				return;
			end
			want = CNT_W'(expected_counts.pop_front());
			if (actual !== want) begin
				errors++;
				$display("%0t: component_count expected %0d, actual %0d",
					$time, want, actual);
			end
		endfunction

		function int pending();
			return expected_counts.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [PIX_W-1:0]   red;
	logic [PIX_W-1:0]   green;
	logic [PIX_W-1:0]   blue;
	logic               last_pixel;
	logic               out_valid;
	logic               out_stall;
	logic [CNT_W-1:0]   component_count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [DIM_W-1:0]   cfg_data;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_request = 1'b0;
	int unsigned pixels_sent = 0;
	int unsigned reg_writes = 0;
	component_scoreboard sb = new;

	threshold_component_counter uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b, input logic last);
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid = 1'b1;
		red = r;
		green = g;
		blue = b;
		last_pixel = last;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(r, g, b, last);
		pixels_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drop input, wait for every count, then let trailing pixel writes settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	function automatic logic [DIM_W-1:0] big_dim();
		case ($urandom_range(0, 3))
			0: return DIM_W'(MAX_ROWS);
			1: return DIM_W'($urandom_range(MAX_ROWS + 1, 511));
			2: return DIM_W'(511);
			default: return DIM_W'($urandom_range(200, MAX_ROWS - 1));
		endcase
	endfunction

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_count(component_count);
	end

	initial begin
		int unsigned i, start, phase_no, area, images, kind, density, len, count, thr;
		logic [DIM_W-1:0] rows_val, cols_val;
		logic [PIX_W-1:0] pr, pg, pb;
		bit calm, finished;

		arst_n = 1'b0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		last_pixel = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-pixel images; zero columns acts as one
		write_reg(CFG_ROWS, 9'd1);
		write_reg(CFG_COLS, 9'd0);
		write_reg(CFG_THRESHOLD, 9'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd254, 1'b1);

		// checkerboard with sums right at and just under three times the threshold
		wait_quiet();
		write_reg(CFG_ROWS, 9'd2);
		write_reg(CFG_COLS, 9'd3);
		write_reg(CFG_THRESHOLD, 9'd10);
		send_pixel(8'd10, 8'd10, 8'd10, 1'b0);
		send_pixel(8'd10, 8'd10, 8'd9, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd9, 8'd10, 8'd10, 1'b0);
		send_pixel(8'd30, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd29, 8'd0, 1'b1);

		// short image keeps older marks
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

		// too many pixels: load wraps to the top
		for (i = 0; i < 8; i++)
			send_pixel(PIX_W'(i * 37), PIX_W'(255 - i * 20), PIX_W'(i * 5), i == 7);

		// narrow the image while the load position sits past the new width
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		wait_quiet();
		write_reg(CFG_COLS, 9'd2);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

		start = pixels_sent;
		phase_no = 0;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			wait_quiet();
			calm = (pixels_sent - start >= CALM_AFTER);
			tx_idle_on = !calm && $urandom_range(0, 3) != 0;
			rx_idle_on = !calm && $urandom_range(0, 3) != 0;

			case ($urandom_range(0, 19))
				0: begin
					rows_val = big_dim();
					cols_val = DIM_W'($urandom_range(1, 2));
				end
				1: begin
					cols_val = big_dim();
					rows_val = DIM_W'($urandom_range(1, 2));
				end
				2: begin
					rows_val = '0;
					cols_val = DIM_W'($urandom_range(0, 9));
				end
				3, 4: begin
					rows_val = DIM_W'($urandom_range(9, 20));
					cols_val = DIM_W'($urandom_range(9, 20));
				end
				default: begin
					rows_val = DIM_W'($urandom_range(1, 8));
					cols_val = DIM_W'($urandom_range(1, 8));
				end
			endcase
			if (phase_no == 2) begin
				rows_val = DIM_W'($urandom_range(2, 4));
				cols_val = DIM_W'($urandom_range(2, 4));
			end
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_ROWS, rows_val);
				write_reg(CFG_COLS, cols_val);
			end else begin
				write_reg(CFG_COLS, cols_val);
				write_reg(CFG_ROWS, rows_val);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: write_reg(CFG_THRESHOLD, 9'd0);
					1: write_reg(CFG_THRESHOLD, 9'd255);
					default: write_reg(CFG_THRESHOLD, DIM_W'($urandom_range(0, 255)));
				endcase
			end
			if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, DIM_W'($urandom_range(0, 511)));

			area = sb.rows_used() * sb.cols_used();
			images = (area > 64) ? 1 : $urandom_range(1, 4);
			// long output hold-off while the sender keeps pushing small images
			if (phase_no == 2) begin
				images = 6;
				tx_idle_on = 1'b0;
				@(posedge clk);
				hold_request = 1'b1;
			end

			repeat (images) begin
				kind = $urandom_range(0, 99);
				density = $urandom_range(5, 95);
				if (kind < 70) len = area;
				else if (kind < 82) len = area + $urandom_range(1, area);
				else len = $urandom_range(1, area);
				count = 0;
				finished = 1'b0;
				while (!finished) begin
					count++;
					// extend a short image until no unwritten entry would be scanned
					finished = (count >= len) && sb.region_ready();
					thr = 32'(sb.thr_reg);
					if ($urandom_range(0, 9) == 0) begin
						pr = PIX_W'($urandom);
						pg = PIX_W'($urandom);
						pb = PIX_W'($urandom);
					end else if (thr == 0 || $urandom_range(0, 99) < density) begin
						pr = PIX_W'($urandom_range(thr, 255));
						pg = PIX_W'($urandom_range(thr, 255));
						pb = PIX_W'($urandom_range(thr, 255));
					end else begin
						pr = PIX_W'($urandom_range(0, thr - 1));
						pg = PIX_W'($urandom_range(0, thr - 1));
						pb = PIX_W'($urandom_range(0, thr - 1));
					end
					send_pixel(pr, pg, pb, finished);
				end
			end
			phase_no++;
		end

		wait_quiet();
		$display("Run covered %0d pixels in %0d setting phases with %0d register writes",
			pixels_sent, phase_no, reg_writes);
		$display("Compared %0d component counts, sizes from 1x1 up to a full %0d-pixel line",
			sb.checked, MAX_COLS);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
